// ----- rtl/core/fam_pkg.sv -----
// ----------------------------------------------------------------------------
// fam_pkg
// shared types, constants and helpers of the automaton pattern matcher
// ----------------------------------------------------------------------------
package fam_pkg;

   // sizing
   localparam int MAX_PATTERN   = 16;
   localparam int POSITION_BITS = 16;
   localparam int PAT_STORE     = 16;
   localparam int PAT_CAP       = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE;
   localparam int STATE_BITS    = $clog2(PAT_CAP + 1);
   localparam int POS_WIDE      = POSITION_BITS + 1;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // register interface
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int LENGTH_BITS    = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LO     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HI     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 5'd1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       sentence_start;
   } req_type;

   typedef struct packed {
      logic        match_found;
      logic [15:0] match_offset;
   } rsp_type;

   // pattern-derived lookup data, rebuilt every cycle from the registers
   typedef struct packed {
      logic [PAT_CAP-1:0][7:0]           pat;
      logic [STATE_BITS-1:0]             len;
      logic [PAT_CAP:0][PAT_CAP:0]       border;
   } fam_tbl_type;

   // fold A-Z to lower case
   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/finite_automaton_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// finite_automaton_pattern_matcher: streaming byte matcher, one rsp per req;
// a req is held in the input register, then in the result register that
// drives rsp; 1 transaction per cycle while rsp_ready does not stall
// the rate is set by the next-state loop through the state register
// synchronous reset clears pipeline, automaton state, position and pattern
// ----------------------------------------------------------------------------
module finite_automaton_pattern_matcher (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fam_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fam_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fam_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fam_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import fam_pkg::*;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_lo_ff, pattern_lo_in;
   logic [CSR_DATA_BITS-1:0] pattern_hi_ff, pattern_hi_in;
   logic [LENGTH_BITS-1:0]   pattern_length_ff, pattern_length_in;
   logic                     csr_hit;

   // input register stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // automaton state
   logic [STATE_BITS-1:0]    state_ff, state_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   // result register stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   fam_tbl_type tbl;

   logic                     advance;
   logic                     req_fire;
   logic [STATE_BITS-1:0]    cur_state;
   logic [POSITION_BITS-1:0] cur_pos;
   logic [STATE_BITS-1:0]    nxt_state;
   logic [7:0]               text_char;
   logic [POS_WIDE-1:0]      pos_plus;
   logic [POS_WIDE-1:0]      len_wide;
   logic                     found;

   // ---------------------------------------------------------------------
   // configuration port, always ready; any known write restarts the automaton
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      pattern_lo_in     = pattern_lo_ff;
      pattern_hi_in     = pattern_hi_ff;
      pattern_length_in = pattern_length_ff;
      csr_hit           = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LO: begin
               pattern_lo_in = csr_data;
               csr_hit       = 1'b1;
            end
            CSR_PATTERN_HI: begin
               pattern_hi_in = csr_data;
               csr_hit       = 1'b1;
            end
            CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_data[LENGTH_BITS-1:0];
               csr_hit           = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // folded pattern and border table, registered from the configuration registers
   fam_table u_table (
      .clock          (clock),
      .pattern_lo     (pattern_lo_ff),
      .pattern_hi     (pattern_hi_ff),
      .pattern_length (pattern_length_ff),
      .tbl_ff         (tbl)
   );

   // ---------------------------------------------------------------------
   // handshake: item moves from input register to result register when
   // the result register is empty or its transaction completes
   // ---------------------------------------------------------------------
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   // sentence start clears state and position before this byte
   assign cur_state = in_data_ff.sentence_start ? '0 : state_ff;
   assign cur_pos   = in_data_ff.sentence_start ? '0 : pos_ff;
   assign text_char = fold(in_data_ff.text_byte);

   fam_next u_next (
      .tbl        (tbl),
      .cur_state  (cur_state),
      .text_char  (text_char),
      .next_state (nxt_state)
   );

   // match bookkeeping: offset is position + 1 - length, guarded at zero
   assign found    = (nxt_state == tbl.len);
   assign pos_plus = {1'b0, cur_pos} + POS_WIDE'(1);
   assign len_wide = POS_WIDE'(tbl.len);

   always_comb begin
      out_data_in.match_found  = found;
      out_data_in.match_offset = '0;
      if (found && pos_plus >= len_wide) begin
         out_data_in.match_offset = 16'(pos_plus - len_wide);
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      if (advance) begin
         state_in = nxt_state;
         // position saturates at its top value
         pos_in   = (cur_pos < POS_MAX) ? cur_pos + POSITION_BITS'(1) : cur_pos;
      end
      if (csr_hit) begin
         state_in = '0;
      end
   end

   assign out_valid_in = advance ? 1'b1 : ((out_valid_ff && rsp_ready) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_lo_ff     <= '0;
         pattern_hi_ff     <= '0;
         pattern_length_ff <= LENGTH_RESET;
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         state_ff          <= '0;
         pos_ff            <= '0;
      end else begin
         pattern_lo_ff     <= pattern_lo_in;
         pattern_hi_ff     <= pattern_hi_in;
         pattern_length_ff <= pattern_length_in;
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         state_ff          <= state_in;
         pos_ff            <= pos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

`ifndef SYNTHESIS
   // a held input transaction is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input register lost a transaction");

   // a register write restarts the automaton
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && (csr_index == CSR_PATTERN_LO || csr_index == CSR_PATTERN_HI ||
                     csr_index == CSR_PATTERN_LENGTH)) |=> (state_ff == '0))
      else $error("state not cleared after register write");

   // position only moves forward within a sentence
   a_pos_mono: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_data_ff.sentence_start) |=> (pos_ff >= $past(pos_ff)))
      else $error("position went backward");

   // no offset without a match
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.match_found) |-> (rsp_payload.match_offset == '0))
      else $error("offset set without match");
`endif

endmodule

// ----- rtl/core/fam_table.sv -----
// ----------------------------------------------------------------------------
// fam_table
// registers the folded pattern, clamped length and the border table
// ----------------------------------------------------------------------------
module fam_table (
   input  logic                                 clock,
   input  logic [fam_pkg::CSR_DATA_BITS-1:0]    pattern_lo,
   input  logic [fam_pkg::CSR_DATA_BITS-1:0]    pattern_hi,
   input  logic [fam_pkg::LENGTH_BITS-1:0]      pattern_length,
   output fam_pkg::fam_tbl_type                 tbl_ff
);
   import fam_pkg::*;

   fam_tbl_type tbl_in;
   logic [2*CSR_DATA_BITS-1:0] pat_all;
   logic g;

   assign pat_all = {pattern_hi, pattern_lo};

   always_comb begin
      tbl_in = '0;
      for (int k = 0; k < PAT_CAP; k++) begin
         tbl_in.pat[k] = fold(pat_all[8*k +: 8]);
      end
      // clamp length to 1..PAT_CAP
      if (pattern_length == '0) begin
         tbl_in.len = STATE_BITS'(1);
      end else if (pattern_length > LENGTH_BITS'(PAT_CAP)) begin
         tbl_in.len = STATE_BITS'(PAT_CAP);
      end else begin
         tbl_in.len = STATE_BITS'(pattern_length);
      end
      // border[s][l]: prefix of length l-1 equals the l-1 bytes before state s
      for (int s = 0; s <= PAT_CAP; s++) begin
         for (int l = 0; l <= PAT_CAP; l++) begin
            g = 1'b0;
            if (l >= 1 && l <= s) begin
               g = 1'b1;
               for (int i = 0; i < PAT_CAP - 1; i++) begin
                  if (i + 1 < l) begin
                     g = g & (tbl_in.pat[i] == tbl_in.pat[s - l + 1 + i]);
                  end
               end
            end
            tbl_in.border[s][l] = g;
         end
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff <= tbl_in;
   end

endmodule

// ----- rtl/core/fam_next.sv -----
// ----------------------------------------------------------------------------
// fam_next
// automaton transition: next state from current state and folded byte
// ----------------------------------------------------------------------------
module fam_next (
   input  fam_pkg::fam_tbl_type                tbl,
   input  logic [fam_pkg::STATE_BITS-1:0]      cur_state,
   input  logic [7:0]                          text_char,
   output logic [fam_pkg::STATE_BITS-1:0]      next_state
);
   import fam_pkg::*;

   logic [PAT_CAP:0] char_eq;
   logic [PAT_CAP:0] row;
   logic             extend;

   always_comb begin
      char_eq = '0;
      for (int k = 0; k < PAT_CAP; k++) begin
         char_eq[k] = (text_char == tbl.pat[k]);
      end
   end

   assign row    = tbl.border[cur_state];
   assign extend = (cur_state < tbl.len) && char_eq[cur_state];

   // longest fallback prefix wins, direct extension beats all
   always_comb begin
      next_state = '0;
      for (int l = 1; l <= PAT_CAP; l++) begin
         if (char_eq[l-1] && row[l]) begin
            next_state = STATE_BITS'(l);
         end
      end
      if (extend) begin
         next_state = cur_state + STATE_BITS'(1);
      end
   end

endmodule

// ----- tb/finite_automaton_pattern_matcher_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// finite_automaton_pattern_matcher_test
// self-checking bench for the streaming pattern matcher: a short scripted
// sequence of pattern writes and text bytes, random phases built around the
// configured pattern, one longer sentence and four short ones at the end;
// every rsp is checked against an in-bench automaton model or a fixed value
// ----------------------------------------------------------------------------
module finite_automaton_pattern_matcher_test;

   import fam_pkg::*;

   // register index with no register behind it
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 220;
   localparam int LONG_ITEMS    = 64;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_TEXT,
      ROW_FIXED
   } row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [7:0]                text;
      logic                      sos;
      rsp_type                   want;
   } script_row_type;

   // dut connections; the dut inputs are all known from time zero
   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data    = '0;

   // bench-side copy of the pattern registers and automaton state
   logic [63:0]                pat_lo_q    = '0;
   logic [63:0]                pat_hi_q    = '0;
   logic [LENGTH_BITS-1:0]     pat_len_q   = LENGTH_RESET;
   int                         fsm_state   = 0;
   logic [POSITION_BITS-1:0]   sent_pos    = '0;

   // expected rsp transactions in order of their req transactions
   rsp_type                    pending_matches[$];
   script_row_type             directed_script[$];

   int                         mismatches  = 0;
   int                         rsp_seen    = 0;
   int                         items_sent  = 0;
   int                         burst_left  = 0;
   logic                       start_next  = 1'b0;

   // receiver stall pattern state
   int unsigned                stall_age   = 0;
   logic [15:0]                stall_bits  = 16'hFFFF;

   finite_automaton_pattern_matcher u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // automaton model
   // ------------------------------------------------------------------------

   function automatic logic [7:0] lower_case(input logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // raw pattern byte as written, before case folding
   function automatic logic [7:0] raw_pat_byte(input int k);
      if (k < 8) begin
         return pat_lo_q[8*k +: 8];
      end
      if (k < 16) begin
         return pat_hi_q[8*(k-8) +: 8];
      end
      return 8'h00;
   endfunction

   function automatic logic [7:0] pat_char(input int k);
      return lower_case(raw_pat_byte(k));
   endfunction

   // length register clamped to 1..PAT_CAP
   function automatic int active_len();
      int m;
      m = int'(pat_len_q);
      if (m < 1) begin
         m = 1;
      end
      if (m > PAT_CAP) begin
         m = PAT_CAP;
      end
      return m;
   endfunction

   // longest pattern prefix that is a suffix of (matched prefix + x)
   function automatic int next_fsm_state(input int st, input logic [7:0] x, input int m);
      int  len;
      int  i;
      bit  agree;
      if (st > m) begin
         st = m;
      end
      if (st < m && x == pat_char(st)) begin
         return st + 1;
      end
      for (len = st; len > 0; len--) begin
         if (pat_char(len - 1) == x) begin
            agree = 1'b1;
            for (i = 0; i + 1 < len; i++) begin
               if (pat_char(i) != pat_char(st - len + 1 + i)) begin
                  agree = 1'b0;
               end
            end
            if (agree) begin
               return len;
            end
         end
      end
      return 0;
   endfunction

   // advance the model by one text byte and return the rsp it gives
   function automatic rsp_type predict_match(input logic [7:0] b, input logic sos);
      rsp_type     r;
      logic [7:0]  x;
      int          m;
      x = lower_case(b);
      m = active_len();
      r = '0;
      if (sos) begin
         fsm_state = 0;
         sent_pos  = '0;
      end
      fsm_state = next_fsm_state(fsm_state, x, m);
      if (fsm_state == m) begin
         r.match_found = 1'b1;
         // guard against a start before the sentence, cannot really happen
         if (int'(sent_pos) + 1 >= m) begin
            r.match_offset = 16'(int'(sent_pos) + 1 - m);
         end
      end
      if (sent_pos != POS_MAX) begin
         sent_pos = sent_pos + 1'b1;
      end
      return r;
   endfunction

   // any real register write restarts the automaton, position is kept
   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      bit hit;
      hit = 1'b1;
      case (idx)
         CSR_PATTERN_LO: begin
            pat_lo_q = data;
         end
         CSR_PATTERN_HI: begin
            pat_hi_q = data;
         end
         CSR_PATTERN_LENGTH: begin
            pat_len_q = data[LENGTH_BITS-1:0];
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      if (hit) begin
         fsm_state = 0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // small alphabet keeps self-overlapping patterns and frequent matches
   function automatic logic [7:0] alpha_byte();
      logic [7:0] b;
      b = ($urandom_range(0, 4) == 0) ? "c" : (($urandom_range(0, 1) == 1) ? "a" : "b");
      if ($urandom_range(0, 1) == 1) begin
         b = b - 8'h20;
      end
      return b;
   endfunction

   function automatic logic [7:0] mixed_case(input logic [7:0] b);
      if ($urandom_range(0, 1) == 1) begin
         if (b >= "a" && b <= "z") begin
            return b - 8'h20;
         end
         if (b >= "A" && b <= "Z") begin
            return b + 8'h20;
         end
      end
      return b;
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                   input logic [CSR_DATA_BITS-1:0] data);
      script_row_type row;
      row      = '{kind: ROW_CSR, default: '0};
      row.idx  = idx;
      row.data = data;
      directed_script = {directed_script, row};
   endfunction

   function automatic void add_text(input logic [7:0] b, input logic sos);
      script_row_type row;
      row      = '{kind: ROW_TEXT, default: '0};
      row.text = b;
      row.sos  = sos;
      directed_script = {directed_script, row};
   endfunction

   function automatic void add_fixed(input logic [7:0] b, input logic sos,
                                     input logic found, input logic [15:0] off);
      script_row_type row;
      row                   = '{kind: ROW_FIXED, default: '0};
      row.text              = b;
      row.sos               = sos;
      row.want.match_found  = found;
      row.want.match_offset = off;
      directed_script = {directed_script, row};
   endfunction

   // one req transaction; sender runs in bursts with random gaps between them
   task automatic send_item(input logic [7:0] b, input logic sos,
                            input bit fixed, input rsp_type fixed_rsp);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_valid                  <= 1'b1;
      req_payload.text_byte      <= b;
      req_payload.sentence_start <= sos;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      // accepted at this edge: advance the model in transaction order
      predicted = predict_match(b, sos);
      pending_matches = {pending_matches, (fixed ? fixed_rsp : predicted)};
      items_sent++;
   endtask

   // next byte of the random stream, carries a pending sentence start
   task automatic stream_byte(input logic [7:0] b);
      send_item(b, start_next, 1'b0, '0);
      start_next = 1'b0;
   endtask

   // stop sending and let every expected rsp come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) begin
         @(posedge clock);
      end
      // spare time after the last rsp before the next step
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      apply_csr(idx, data);
      csr_valid <= 1'b0;
      // idle gap with valid low so back-to-back writes never toggle valid in one step
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // receiver: stall pattern rotates and is redrawn when its age runs out,
   // a quarter of the stretches never stall
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_age = $urandom_range(32, 128);
         if ($urandom_range(0, 3) == 0) begin
            stall_bits = 16'hFFFF;
         end else begin
            stall_bits    = 16'($urandom);
            stall_bits[0] = 1'b1;
         end
      end
      stall_age--;
      rsp_ready  <= stall_bits[0];
      stall_bits  = {stall_bits[0], stall_bits[15:1]};
   end

   // ------------------------------------------------------------------------
   // rsp checker: each rsp transaction against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("rsp %0d with nothing expected: found=%0d offset=%0d",
                        rsp_seen, rsp_payload.match_found, rsp_payload.match_offset);
            end
         end else begin
            want = pending_matches.pop_front();
            if (rsp_payload.match_found !== want.match_found ||
                rsp_payload.match_offset !== want.match_offset) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("rsp %0d: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                           rsp_seen, want.match_found, want.match_offset,
                           rsp_payload.match_found, rsp_payload.match_offset);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int          phase;
      int          phase_end;
      int          pick;
      int          m;
      int          k;
      int          n;
      logic [63:0] word;

      // after reset: one-byte pattern of 0x00
      add_fixed(8'h00, 1'b1, 1'b1, 16'd0);
      add_fixed(8'h41, 1'b0, 1'b0, 16'd0);
      add_fixed(8'h00, 1'b0, 1'b1, 16'd2);
      add_fixed(8'hFF, 1'b0, 1'b0, 16'd0);
      // mixed-case "abab..." pattern, length 3 with junk in the upper data bits
      add_csr(CSR_PATTERN_LO, 64'h4241_4241_4241_4241);
      add_csr(CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3);
      add_text("x", 1'b1);
      add_text("a", 1'b0);
      add_text("B", 1'b0);
      add_fixed("A", 1'b0, 1'b1, 16'd1);
      add_text("b", 1'b0);
      // overlapping match
      add_fixed("a", 1'b0, 1'b1, 16'd3);
      // write to the unused index must leave the automaton alone
      add_csr(CSR_UNUSED, 64'h0123_4567_89AB_CDEF);
      add_text("b", 1'b0);
      add_fixed("a", 1'b0, 1'b1, 16'd5);
      add_text("b", 1'b0);
      // rewriting the pattern restarts the automaton mid-sentence
      add_csr(CSR_PATTERN_LO, 64'h4241_4241_4241_4241);
      add_fixed("a", 1'b0, 1'b0, 16'd0);
      // zero length behaves as length one
      add_csr(CSR_PATTERN_LENGTH, 64'd0);
      add_text("A", 1'b0);
      add_text(8'h5B, 1'b0);
      add_text(8'h40, 1'b0);
      // oversized length clamps to the full sixteen bytes
      add_csr(CSR_PATTERN_HI, 64'h7A59_5A41_0000_FF80);
      add_csr(CSR_PATTERN_LENGTH, 64'd31);
      add_text(8'h5A, 1'b1);
      add_text(8'hC1, 1'b0);
      // single "Z" folds to "z"; bytes with the top bit set are not letters
      add_csr(CSR_PATTERN_LO, 64'h0000_0000_0000_005A);
      add_csr(CSR_PATTERN_LENGTH, 64'd1);
      add_fixed("z", 1'b1, 1'b1, 16'd0);
      add_fixed("Z", 1'b0, 1'b1, 16'd1);
      add_fixed(8'hDA, 1'b0, 1'b0, 16'd0);
      add_fixed(8'h80, 1'b1, 1'b0, 16'd0);

      // synchronous reset, asserted once
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script
      foreach (directed_script[i]) begin
         case (directed_script[i].kind)
            ROW_CSR: begin
               wait_idle();
               csr_write(directed_script[i].idx, directed_script[i].data);
            end
            ROW_TEXT: begin
               send_item(directed_script[i].text, directed_script[i].sos, 1'b0, '0);
            end
            default: begin
               send_item(directed_script[i].text, directed_script[i].sos, 1'b1,
                         directed_script[i].want);
            end
         endcase
      end

      // random phases, each with its own pattern and length
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         if (phase == 5 || $urandom_range(0, 3) == 0) begin
            csr_write(CSR_PATTERN_LO, {$urandom, $urandom});
            csr_write(CSR_PATTERN_HI, {$urandom, $urandom});
         end else begin
            for (k = 0; k < 8; k++) begin
               word[8*k +: 8] = alpha_byte();
            end
            csr_write(CSR_PATTERN_LO, word);
            for (k = 0; k < 8; k++) begin
               word[8*k +: 8] = alpha_byte();
            end
            csr_write(CSR_PATTERN_HI, word);
         end
         if ($urandom_range(0, 2) == 0) begin
            csr_write(CSR_UNUSED, {$urandom, $urandom});
         end
         // extremes first, then anything the field holds
         case (phase)
            0:       csr_write(CSR_PATTERN_LENGTH, 64'd1);
            1:       csr_write(CSR_PATTERN_LENGTH, 64'd16);
            2:       csr_write(CSR_PATTERN_LENGTH, 64'd0);
            3:       csr_write(CSR_PATTERN_LENGTH, 64'd31);
            default: csr_write(CSR_PATTERN_LENGTH, {$urandom, $urandom});
         endcase
         start_next = 1'b1;
         phase_end  = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            m    = active_len();
            if (pick < 8) begin
               start_next = 1'b1;
            end else if (pick < 50) begin
               // whole pattern in random case, repeats give overlaps
               for (k = 0; k < m; k++) begin
                  stream_byte(mixed_case(raw_pat_byte(k)));
               end
            end else if (pick < 70) begin
               // broken-off prefix
               n = $urandom_range(1, m);
               for (k = 0; k < n; k++) begin
                  stream_byte(mixed_case(raw_pat_byte(k)));
               end
            end else if (pick < 72) begin
               // hold off until the pipeline is empty
               wait_idle();
            end else begin
               n = $urandom_range(1, 4);
               for (k = 0; k < n; k++) begin
                  stream_byte(($urandom_range(0, 1) == 1) ? 8'($urandom) : alpha_byte());
               end
            end
         end
      end

      // one longer sentence on a short pattern
      wait_idle();
      for (k = 0; k < 8; k++) begin
         word[8*k +: 8] = alpha_byte();
      end
      csr_write(CSR_PATTERN_LO, word);
      csr_write(CSR_PATTERN_LENGTH, 64'($urandom_range(1, 3)));
      start_next = 1'b1;
      repeat (LONG_ITEMS) begin
         stream_byte(alpha_byte());
      end
      // a new sentence starts again from zero
      repeat (4) begin
         start_next = 1'b1;
         stream_byte(mixed_case(raw_pat_byte(0)));
         stream_byte(mixed_case(raw_pat_byte(1)));
      end

      // drain, then allow for stray rsp transactions
      wait_idle();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit, well above the slowest legal run
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/fam_pkg.sv
rtl/core/fam_table.sv
rtl/core/fam_next.sv
rtl/core/finite_automaton_pattern_matcher.sv
tb/finite_automaton_pattern_matcher_test.sv
